// ===== rtl/hrk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrk_pkg
// Shared types, widths and constants of the HSV range pixel key.
// ----------------------------------------------------------------------------
package hrk_pkg;

    localparam int CH_W     = 8;
    localparam int QUO_W    = 7;
    localparam int DVD_W    = QUO_W + CH_W;
    localparam int HUE_W    = 10;
    localparam int BASE_W   = 9;
    localparam int PCT_W    = 7;
    localparam int FILL_W   = 25;
    localparam int COLOR_W  = 3 * CH_W;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam int FILL_EN_BIT = 24;

    localparam logic [HUE_W-1:0]  HUE_FULL    = 10'd360;
    localparam logic [BASE_W-1:0] HUE_HALF    = 9'd180;
    localparam logic [BASE_W-1:0] HUE_RED     = 9'd0;
    localparam logic [BASE_W-1:0] HUE_RED_NEG = 9'd360;
    localparam logic [BASE_W-1:0] HUE_GREEN   = 9'd120;
    localparam logic [BASE_W-1:0] HUE_BLUE    = 9'd240;
    localparam logic [DVD_W-1:0]  HUE_MUL     = 15'd60;
    localparam logic [DVD_W-1:0]  PCT_MUL     = 15'd100;
    localparam logic [PCT_W-1:0]  PCT_MAX     = 7'd100;
    localparam logic [QUO_W-1:0]  HUE_Q_MAX   = 7'd60;

    typedef enum logic [2:0] {
        REG_HUE_LOW    = 3'd0,
        REG_HUE_HIGH   = 3'd1,
        REG_SAT_LOW    = 3'd2,
        REG_SAT_HIGH   = 3'd3,
        REG_VAL_LOW    = 3'd4,
        REG_VAL_HIGH   = 3'd5,
        REG_MATCH_FILL = 3'd6,
        REG_MISS_FILL  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue_low;
        logic [HUE_W-1:0]  hue_high;
        logic [PCT_W-1:0]  sat_low;
        logic [PCT_W-1:0]  sat_high;
        logic [PCT_W-1:0]  val_low;
        logic [PCT_W-1:0]  val_high;
        logic [FILL_W-1:0] match_fill;
        logic [FILL_W-1:0] miss_fill;
    } cfg_t;

    typedef struct packed {
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [BASE_W-1:0] base;
        logic              neg;
        logic              gray;
        logic [PCT_W-1:0]  val;
    } pix_side_t;

endpackage

// ===== rtl/hrk_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrk_front
// Finds the largest and smallest channel, the hue sector and its offset,
// the value percent, and the two dividends and divisors for the divider.
// ----------------------------------------------------------------------------
module hrk_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [hrk_pkg::CH_W-1:0]    in_red,
    input  logic [hrk_pkg::CH_W-1:0]    in_green,
    input  logic [hrk_pkg::CH_W-1:0]    in_blue,
    output logic                        out_valid,
    input  logic                        out_ready,
    output hrk_pkg::pix_side_t          out_side,
    output logic [hrk_pkg::DVD_W-1:0]   out_hue_dvd,
    output logic [hrk_pkg::CH_W-1:0]    out_hue_dsor,
    output logic [hrk_pkg::DVD_W-1:0]   out_sat_dvd,
    output logic [hrk_pkg::CH_W-1:0]    out_sat_dsor
);

    logic                      valid_reg;
    hrk_pkg::pix_side_t        side_reg, side_next;
    logic [hrk_pkg::DVD_W-1:0] hue_dvd_reg, hue_dvd_next;
    logic [hrk_pkg::CH_W-1:0]  hue_dsor_reg, hue_dsor_next;
    logic [hrk_pkg::DVD_W-1:0] sat_dvd_reg, sat_dvd_next;
    logic [hrk_pkg::CH_W-1:0]  sat_dsor_reg, sat_dsor_next;

    logic [hrk_pkg::CH_W-1:0]   mx, mn, d, a, c, y;
    logic [hrk_pkg::BASE_W-1:0] base;
    logic                       red_max;
    logic [hrk_pkg::DVD_W-1:0]  val_prod, val_sum;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        mx = in_red;
        mn = in_red;
        if (in_green > mx) mx = in_green;
        if (in_blue > mx) mx = in_blue;
        if (in_green < mn) mn = in_green;
        if (in_blue < mn) mn = in_blue;
        d = mx - mn;

        red_max = 1'b0;
        priority if (in_red >= in_green && in_red >= in_blue) begin
            a       = in_green;
            c       = in_blue;
            base    = hrk_pkg::HUE_RED;
            red_max = 1'b1;
        end else if (in_green >= in_blue) begin
            a    = in_blue;
            c    = in_red;
            base = hrk_pkg::HUE_GREEN;
        end else begin
            a    = in_red;
            c    = in_green;
            base = hrk_pkg::HUE_BLUE;
        end

        // Floor of x/255 for x below 65536 is (x + (x >> 8) + 1) >> 8.
        val_prod = hrk_pkg::DVD_W'(mx) * hrk_pkg::PCT_MUL;
        val_sum  = val_prod + (val_prod >> 8) + hrk_pkg::DVD_W'(1);

        side_next.red   = in_red;
        side_next.green = in_green;
        side_next.blue  = in_blue;
        side_next.neg   = (a < c);
        side_next.gray  = (d == '0);
        side_next.base  = (side_next.neg && red_max) ? hrk_pkg::HUE_RED_NEG : base;
        side_next.val   = val_sum[8 +: hrk_pkg::PCT_W];

        y             = side_next.neg ? (c - a) : (a - c);
        hue_dvd_next  = hrk_pkg::DVD_W'(y) * hrk_pkg::HUE_MUL;
        hue_dsor_next = d;
        sat_dvd_next  = hrk_pkg::DVD_W'(d) * hrk_pkg::PCT_MUL;
        sat_dsor_next = mx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            side_reg     <= side_next;
            hue_dvd_reg  <= hue_dvd_next;
            hue_dsor_reg <= hue_dsor_next;
            sat_dvd_reg  <= sat_dvd_next;
            sat_dsor_reg <= sat_dsor_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_side     = side_reg;
    assign out_hue_dvd  = hue_dvd_reg;
    assign out_hue_dsor = hue_dsor_reg;
    assign out_sat_dvd  = sat_dvd_reg;
    assign out_sat_dsor = sat_dsor_reg;

endmodule

// ===== rtl/hrk_div_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrk_div_pipe
// Two restoring dividers side by side, one quotient bit per stage, with a
// side band that travels along. Each stage has its own valid bit.
// ----------------------------------------------------------------------------
module hrk_div_pipe #(
    parameter int QW = hrk_pkg::QUO_W,
    parameter int DW = hrk_pkg::CH_W,
    parameter int SW = $bits(hrk_pkg::pix_side_t)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [SW-1:0]   in_side,
    input  logic [QW+DW-1:0] in_a_dvd,
    input  logic [DW-1:0]   in_a_dsor,
    input  logic [QW+DW-1:0] in_b_dvd,
    input  logic [DW-1:0]   in_b_dsor,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [SW-1:0]   out_side,
    output logic [QW-1:0]   out_a_quo,
    output logic            out_a_rem_nz,
    output logic [QW-1:0]   out_b_quo
);

    localparam int NW = QW + DW;

    logic          valid_reg  [QW];
    logic [NW-1:0] a_rem_reg  [QW];
    logic [NW-1:0] b_rem_reg  [QW];
    logic [DW-1:0] a_dsor_reg [QW];
    logic [DW-1:0] b_dsor_reg [QW];
    logic [QW-1:0] a_quo_reg  [QW];
    logic [QW-1:0] b_quo_reg  [QW];
    logic [SW-1:0] side_reg   [QW];

    logic          valid_src  [QW];
    logic [NW-1:0] a_rem_src  [QW];
    logic [NW-1:0] b_rem_src  [QW];
    logic [DW-1:0] a_dsor_src [QW];
    logic [DW-1:0] b_dsor_src [QW];
    logic [QW-1:0] a_quo_src  [QW];
    logic [QW-1:0] b_quo_src  [QW];
    logic [SW-1:0] side_src   [QW];

    logic          rdy [QW+1];

    assign rdy[QW]  = out_ready;
    assign in_ready = rdy[0];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int BIT = QW - 1 - k;

        logic [NW-1:0] a_sub, b_sub;
        logic          a_ge, b_ge;
        logic [NW-1:0] a_rem_next, b_rem_next;
        logic [QW-1:0] a_quo_next, b_quo_next;

        if (k == 0) begin : g_head
            assign valid_src[k]  = in_valid;
            assign a_rem_src[k]  = in_a_dvd;
            assign b_rem_src[k]  = in_b_dvd;
            assign a_dsor_src[k] = in_a_dsor;
            assign b_dsor_src[k] = in_b_dsor;
            assign a_quo_src[k]  = '0;
            assign b_quo_src[k]  = '0;
            assign side_src[k]   = in_side;
        end else begin : g_link
            assign valid_src[k]  = valid_reg[k-1];
            assign a_rem_src[k]  = a_rem_reg[k-1];
            assign b_rem_src[k]  = b_rem_reg[k-1];
            assign a_dsor_src[k] = a_dsor_reg[k-1];
            assign b_dsor_src[k] = b_dsor_reg[k-1];
            assign a_quo_src[k]  = a_quo_reg[k-1];
            assign b_quo_src[k]  = b_quo_reg[k-1];
            assign side_src[k]   = side_reg[k-1];
        end

        assign rdy[k] = !valid_reg[k] || rdy[k+1];

        always_comb begin
            a_sub      = NW'(a_dsor_src[k]) << BIT;
            b_sub      = NW'(b_dsor_src[k]) << BIT;
            a_ge       = (a_rem_src[k] >= a_sub);
            b_ge       = (b_rem_src[k] >= b_sub);
            a_rem_next = a_ge ? (a_rem_src[k] - a_sub) : a_rem_src[k];
            b_rem_next = b_ge ? (b_rem_src[k] - b_sub) : b_rem_src[k];
            a_quo_next = a_quo_src[k] | (QW'(a_ge) << BIT);
            b_quo_next = b_quo_src[k] | (QW'(b_ge) << BIT);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                valid_reg[k] <= valid_src[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && valid_src[k]) begin
                a_rem_reg[k]  <= a_rem_next;
                b_rem_reg[k]  <= b_rem_next;
                a_dsor_reg[k] <= a_dsor_src[k];
                b_dsor_reg[k] <= b_dsor_src[k];
                a_quo_reg[k]  <= a_quo_next;
                b_quo_reg[k]  <= b_quo_next;
                side_reg[k]   <= side_src[k];
            end
        end
    end

    assign out_valid    = valid_reg[QW-1];
    assign out_side     = side_reg[QW-1];
    assign out_a_quo    = a_quo_reg[QW-1];
    assign out_a_rem_nz = |a_rem_reg[QW-1];
    assign out_b_quo    = b_quo_reg[QW-1];

endmodule

// ===== rtl/hrk_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrk_match
// Builds hue and saturation from the quotients, applies the hue wrap, checks
// the three ranges and selects the fill color or the original pixel.
// ----------------------------------------------------------------------------
module hrk_match (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  hrk_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  hrk_pkg::pix_side_t          in_side,
    input  logic [hrk_pkg::QUO_W-1:0]   in_hue_q,
    input  logic                        in_hue_rem_nz,
    input  logic [hrk_pkg::QUO_W-1:0]   in_sat_q,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [hrk_pkg::COLOR_W-1:0] out_color,
    output logic                        out_in_range
);

    logic                         hsv_valid_reg;
    logic [hrk_pkg::HUE_W-1:0]    hue_reg, hue_next;
    logic [hrk_pkg::PCT_W-1:0]    sat_reg, sat_next;
    logic [hrk_pkg::PCT_W-1:0]    val_reg;
    logic [hrk_pkg::COLOR_W-1:0]  pix_reg;
    logic                         hsv_ready;

    logic                         res_valid_reg;
    logic [hrk_pkg::COLOR_W-1:0]  color_reg, color_next;
    logic                         hit_reg, hit_next;

    logic [hrk_pkg::BASE_W-1:0]   hue_raw;
    logic [hrk_pkg::FILL_W-1:0]   fill;

    assign hsv_ready = !res_valid_reg || out_ready;
    assign in_ready  = !hsv_valid_reg || hsv_ready;

    always_comb begin
        if (in_side.gray) begin
            hue_raw = '0;
        end else if (in_side.neg) begin
            hue_raw = in_side.base - hrk_pkg::BASE_W'(in_hue_q)
                    - hrk_pkg::BASE_W'(in_hue_rem_nz);
        end else begin
            hue_raw = in_side.base + hrk_pkg::BASE_W'(in_hue_q);
        end
        hue_next = hrk_pkg::HUE_W'(hue_raw);
        if (cfg.hue_high > hrk_pkg::HUE_FULL && hue_raw < hrk_pkg::HUE_HALF) begin
            hue_next = hrk_pkg::HUE_W'(hue_raw) + hrk_pkg::HUE_FULL;
        end
        sat_next = in_side.gray ? '0 : in_sat_q;
    end

    always_comb begin
        hit_next = (cfg.hue_low <= hue_reg) && (hue_reg <= cfg.hue_high)
                && (cfg.sat_low <= sat_reg) && (sat_reg <= cfg.sat_high)
                && (cfg.val_low <= val_reg) && (val_reg <= cfg.val_high);
        fill = hit_next ? cfg.match_fill : cfg.miss_fill;
        color_next = fill[hrk_pkg::FILL_EN_BIT] ? fill[hrk_pkg::COLOR_W-1:0] : pix_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hsv_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                hsv_valid_reg <= in_valid;
            end
            if (hsv_ready) begin
                res_valid_reg <= hsv_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= in_side.val;
            pix_reg <= {in_side.red, in_side.green, in_side.blue};
        end
        if (hsv_ready && hsv_valid_reg) begin
            color_reg <= color_next;
            hit_reg   <= hit_next;
        end
    end

    assign out_valid    = res_valid_reg;
    assign out_color    = color_reg;
    assign out_in_range = hit_reg;

endmodule

// ===== rtl/hsv_range_pixel_key.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_range_pixel_key
// Converts each pixel to hue, saturation and value, keys it against three
// programmable ranges and replaces it with a match or miss fill color.
//
// Channel   Direction  Word
// s_*       in         tdata[23:0] = blue, green, red
// m_*       out        tdata[23:0] = blue, green, red; tuser[0] = in range
// APB       in/out     eight registers at byte address 4*i
//
// One word per cycle is accepted and delivered while m_tready is high; the
// pipeline has one front stage, seven divider stages (one quotient bit each)
// and two stages for the range check and fill. Every stage has its own valid
// bit, so a stall at m_tready fills the empty stages before s_tready drops.
// Reset is synchronous, clears the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module hsv_range_pixel_key (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,   // blue, green, red
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,   // res_blue, res_green, res_red
    output logic [0:0]                   m_tuser,   // in_range

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hrk_pkg::ADDR_W-1:0]   paddr,
    input  logic [hrk_pkg::DATA_W-1:0]   pwdata,
    output logic [hrk_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    hrk_pkg::cfg_t               cfg_reg, cfg_next;
    hrk_pkg::reg_idx_t           reg_idx;
    logic                        cfg_write;

    logic                        front_valid, front_ready;
    hrk_pkg::pix_side_t          front_side;
    logic [hrk_pkg::DVD_W-1:0]   front_hue_dvd, front_sat_dvd;
    logic [hrk_pkg::CH_W-1:0]    front_hue_dsor, front_sat_dsor;

    logic                        div_valid, div_ready;
    logic [$bits(hrk_pkg::pix_side_t)-1:0] div_side_bits;
    hrk_pkg::pix_side_t          div_side;
    logic [hrk_pkg::QUO_W-1:0]   div_hue_q, div_sat_q;
    logic                        div_hue_rem_nz;

    logic [hrk_pkg::COLOR_W-1:0] res_color;
    logic                        res_in_range;

    assign pready    = 1'b1;
    assign reg_idx   = hrk_pkg::reg_idx_t'(paddr[hrk_pkg::ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (reg_idx)
                hrk_pkg::REG_HUE_LOW:    cfg_next.hue_low    = pwdata[hrk_pkg::HUE_W-1:0];
                hrk_pkg::REG_HUE_HIGH:   cfg_next.hue_high   = pwdata[hrk_pkg::HUE_W-1:0];
                hrk_pkg::REG_SAT_LOW:    cfg_next.sat_low    = pwdata[hrk_pkg::PCT_W-1:0];
                hrk_pkg::REG_SAT_HIGH:   cfg_next.sat_high   = pwdata[hrk_pkg::PCT_W-1:0];
                hrk_pkg::REG_VAL_LOW:    cfg_next.val_low    = pwdata[hrk_pkg::PCT_W-1:0];
                hrk_pkg::REG_VAL_HIGH:   cfg_next.val_high   = pwdata[hrk_pkg::PCT_W-1:0];
                hrk_pkg::REG_MATCH_FILL: cfg_next.match_fill = pwdata[hrk_pkg::FILL_W-1:0];
                hrk_pkg::REG_MISS_FILL:  cfg_next.miss_fill  = pwdata[hrk_pkg::FILL_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            hrk_pkg::REG_HUE_LOW:    prdata = hrk_pkg::DATA_W'(cfg_reg.hue_low);
            hrk_pkg::REG_HUE_HIGH:   prdata = hrk_pkg::DATA_W'(cfg_reg.hue_high);
            hrk_pkg::REG_SAT_LOW:    prdata = hrk_pkg::DATA_W'(cfg_reg.sat_low);
            hrk_pkg::REG_SAT_HIGH:   prdata = hrk_pkg::DATA_W'(cfg_reg.sat_high);
            hrk_pkg::REG_VAL_LOW:    prdata = hrk_pkg::DATA_W'(cfg_reg.val_low);
            hrk_pkg::REG_VAL_HIGH:   prdata = hrk_pkg::DATA_W'(cfg_reg.val_high);
            hrk_pkg::REG_MATCH_FILL: prdata = hrk_pkg::DATA_W'(cfg_reg.match_fill);
            hrk_pkg::REG_MISS_FILL:  prdata = hrk_pkg::DATA_W'(cfg_reg.miss_fill);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hue_low    <= '0;
            cfg_reg.hue_high   <= hrk_pkg::HUE_FULL;
            cfg_reg.sat_low    <= '0;
            cfg_reg.sat_high   <= hrk_pkg::PCT_MAX;
            cfg_reg.val_low    <= '0;
            cfg_reg.val_high   <= hrk_pkg::PCT_MAX;
            cfg_reg.match_fill <= '0;
            cfg_reg.miss_fill  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hrk_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_red       (s_tdata[23:16]),
        .in_green     (s_tdata[15:8]),
        .in_blue      (s_tdata[7:0]),
        .out_valid    (front_valid),
        .out_ready    (front_ready),
        .out_side     (front_side),
        .out_hue_dvd  (front_hue_dvd),
        .out_hue_dsor (front_hue_dsor),
        .out_sat_dvd  (front_sat_dvd),
        .out_sat_dsor (front_sat_dsor)
    );

    hrk_div_pipe #(
        .QW (hrk_pkg::QUO_W),
        .DW (hrk_pkg::CH_W),
        .SW ($bits(hrk_pkg::pix_side_t))
    ) u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (front_valid),
        .in_ready     (front_ready),
        .in_side      (front_side),
        .in_a_dvd     (front_hue_dvd),
        .in_a_dsor    (front_hue_dsor),
        .in_b_dvd     (front_sat_dvd),
        .in_b_dsor    (front_sat_dsor),
        .out_valid    (div_valid),
        .out_ready    (div_ready),
        .out_side     (div_side_bits),
        .out_a_quo    (div_hue_q),
        .out_a_rem_nz (div_hue_rem_nz),
        .out_b_quo    (div_sat_q)
    );

    assign div_side = hrk_pkg::pix_side_t'(div_side_bits);

    hrk_match u_match (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (div_valid),
        .in_ready      (div_ready),
        .in_side       (div_side),
        .in_hue_q      (div_hue_q),
        .in_hue_rem_nz (div_hue_rem_nz),
        .in_sat_q      (div_sat_q),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_color     (res_color),
        .out_in_range  (res_in_range)
    );

    assign m_tdata    = res_color;
    assign m_tuser[0] = res_in_range;

    // The input side only stalls when every stage is full and the output waits.
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the pipeline has room");

    // Saturation is d/max with d never above max, so at most 100.
    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_valid && !div_side.gray) |-> (div_sat_q <= hrk_pkg::PCT_MAX))
        else $error("saturation quotient out of range");

    // The hue fraction is 60*y/d with y never above d, so at most 60.
    a_hue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_valid && !div_side.gray) |-> (div_hue_q <= hrk_pkg::HUE_Q_MAX))
        else $error("hue quotient out of range");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HSV range pixel key. Pixels are streamed in
// with random gaps while the result side stalls at random. A scoreboard
// class predicts each keyed pixel from its own copy of the registers and
// compares every delivered word, field by field, in order. The registers
// are reprogrammed over the APB port between drained phases: reset values,
// hue wrap, empty and full ranges, over-wide writes and random settings.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic [hrk_pkg::COLOR_W-1:0] color;
        logic                        hit;
    } key_word_t;

    class pixel_key_board;
        hrk_pkg::cfg_t cfg;
        key_word_t     awaited[$];
        int            errors;

        function new();
            cfg = '0;
            cfg.hue_high = hrk_pkg::HUE_FULL;
            cfg.sat_high = hrk_pkg::PCT_MAX;
            cfg.val_high = hrk_pkg::PCT_MAX;
            errors = 0;
        endfunction

        function void set_reg(hrk_pkg::reg_idx_t idx, logic [hrk_pkg::DATA_W-1:0] value);
            case (idx)
                hrk_pkg::REG_HUE_LOW:    cfg.hue_low    = value[hrk_pkg::HUE_W-1:0];
                hrk_pkg::REG_HUE_HIGH:   cfg.hue_high   = value[hrk_pkg::HUE_W-1:0];
                hrk_pkg::REG_SAT_LOW:    cfg.sat_low    = value[hrk_pkg::PCT_W-1:0];
                hrk_pkg::REG_SAT_HIGH:   cfg.sat_high   = value[hrk_pkg::PCT_W-1:0];
                hrk_pkg::REG_VAL_LOW:    cfg.val_low    = value[hrk_pkg::PCT_W-1:0];
                hrk_pkg::REG_VAL_HIGH:   cfg.val_high   = value[hrk_pkg::PCT_W-1:0];
                hrk_pkg::REG_MATCH_FILL: cfg.match_fill = value[hrk_pkg::FILL_W-1:0];
                hrk_pkg::REG_MISS_FILL:  cfg.miss_fill  = value[hrk_pkg::FILL_W-1:0];
                default: ;
            endcase
        endfunction

        function key_word_t key_pixel(logic [hrk_pkg::COLOR_W-1:0] px);
            int unsigned r, g, b, mx, mn, d, num, hue, sat, val;
            logic [hrk_pkg::FILL_W-1:0] fill;
            key_word_t w;
            r = 32'(px[23:16]);
            g = 32'(px[15:8]);
            b = 32'(px[7:0]);
            mx = r;
            mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            d = mx - mn;
            val = (100 * mx) / 255;
            if (mx == 0 || d == 0) begin
                sat = 0;
                hue = 0;
            end else begin
                sat = (100 * d) / mx;
                if (mx == r) begin
                    if (g >= b) num = 60 * (g - b);
                    else num = 360 * d - 60 * (b - g);
                end else if (mx == g) begin
                    num = 120 * d + 60 * b - 60 * r;
                end else begin
                    num = 240 * d + 60 * r - 60 * g;
                end
                hue = num / d;
            end
            // A high limit past a full turn lets the range wrap through red.
            if (32'(cfg.hue_high) > 32'(hrk_pkg::HUE_FULL) && hue < 180) hue = hue + 360;
            w.hit = (32'(cfg.hue_low) <= hue && hue <= 32'(cfg.hue_high)) &&
                    (32'(cfg.sat_low) <= sat && sat <= 32'(cfg.sat_high)) &&
                    (32'(cfg.val_low) <= val && val <= 32'(cfg.val_high));
            fill = w.hit ? cfg.match_fill : cfg.miss_fill;
            w.color = fill[hrk_pkg::FILL_EN_BIT] ? fill[hrk_pkg::COLOR_W-1:0] : px;
            return w;
        endfunction

        function void note_pixel(logic [hrk_pkg::COLOR_W-1:0] px);
            awaited.push_back(key_pixel(px));
        endfunction

        function void check_pixel(logic [hrk_pkg::COLOR_W-1:0] data, logic hit);
            key_word_t w;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected word, actual %h in_range %b", $time, data, hit);
                errors++;
                return;
            end
            w = awaited.pop_front();
            if (data[7:0] !== w.color[7:0]) begin
                $display("%0t: res_blue expected %h actual %h",
                         $time, w.color[7:0], data[7:0]);
                errors++;
            end
            if (data[15:8] !== w.color[15:8]) begin
                $display("%0t: res_green expected %h actual %h",
                         $time, w.color[15:8], data[15:8]);
                errors++;
            end
            if (data[23:16] !== w.color[23:16]) begin
                $display("%0t: res_red expected %h actual %h",
                         $time, w.color[23:16], data[23:16]);
                errors++;
            end
            if (hit !== w.hit) begin
                $display("%0t: in_range expected %b actual %b", $time, w.hit, hit);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                        aclk     = 1'b0;
    logic                        aresetn  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [23:0]                 s_tdata  = '0;    // blue, green, red
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [23:0]                 m_tdata;          // res_blue, res_green, res_red
    logic [0:0]                  m_tuser;          // in_range
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [hrk_pkg::ADDR_W-1:0]  paddr    = '0;
    logic [hrk_pkg::DATA_W-1:0]  pwdata   = '0;
    logic [hrk_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    pixel_key_board board = new();
    int idle_pct  = 24;
    int hold_req  = 0;
    int hold_left = 0;
    int quiet     = 0;

    hsv_range_pixel_key dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) board.note_pixel(s_tdata);
        if (aresetn && m_tvalid && m_tready) board.check_pixel(m_tdata, m_tuser[0]);
    end

    always @(posedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet = 0;
        else quiet = quiet + 1;
        if (quiet >= 3000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input hrk_pkg::reg_idx_t idx,
                             input logic [hrk_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_key(input int hl, input int hh, input int sl, input int sh,
                           input int vl, input int vh,
                           input logic [hrk_pkg::FILL_W-1:0] hit_fill,
                           input logic [hrk_pkg::FILL_W-1:0] miss_fill);
        write_reg(hrk_pkg::REG_HUE_LOW, hl);
        write_reg(hrk_pkg::REG_HUE_HIGH, hh);
        write_reg(hrk_pkg::REG_SAT_LOW, sl);
        write_reg(hrk_pkg::REG_SAT_HIGH, sh);
        write_reg(hrk_pkg::REG_VAL_LOW, vl);
        write_reg(hrk_pkg::REG_VAL_HIGH, vh);
        write_reg(hrk_pkg::REG_MATCH_FILL, hrk_pkg::DATA_W'(hit_fill));
        write_reg(hrk_pkg::REG_MISS_FILL, hrk_pkg::DATA_W'(miss_fill));
    endtask

    task automatic send_pixel(input logic [23:0] px);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_pixel();
        logic [7:0] hi, lo, pick [4];
        pick = '{8'd0, 8'd1, 8'd254, 8'd255};
        hi = 8'($urandom_range(0, 255));
        lo = 8'($urandom_range(0, hi));
        case ($urandom_range(0, 9))
            0: return {hi, hi, hi};
            1: case ($urandom_range(0, 2))
                   0: return {hi, hi, lo};
                   1: return {lo, hi, hi};
                   default: return {hi, lo, hi};
               endcase
            2: return {pick[2'($urandom_range(0, 3))], pick[2'($urandom_range(0, 3))],
                       pick[2'($urandom_range(0, 3))]};
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_key();
        int hl, hh, sl, sh, vl, vh;
        hl = $urandom_range(0, 540);
        hh = $urandom_range(0, 540);
        sl = $urandom_range(0, 100);
        sh = $urandom_range(0, 100);
        vl = $urandom_range(0, 100);
        vh = $urandom_range(0, 100);
        if (hh < hl && $urandom_range(0, 3) != 0) {hl, hh} = {hh, hl};
        if (sh < sl && $urandom_range(0, 3) != 0) {sl, sh} = {sh, sl};
        if (vh < vl && $urandom_range(0, 3) != 0) {vl, vh} = {vh, vl};
        set_key(hl, hh, sl, sh, vl, vh, 25'($urandom_range(0, 33554431)),
                25'($urandom_range(0, 33554431)));
    endtask

    initial begin
        logic [23:0] directed [20];
        directed = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000,
                     24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
                     24'hFF0001, 24'hFF0100, 24'h01FF00, 24'h0100FF, 24'h010000,
                     24'h7F0000, 24'h00007F, 24'h102030, 24'hFFFE00, 24'h800040};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_pixel(directed[i]);
        drain();

        set_key(30, 90, 20, 100, 10, 90, {1'b1, 24'(($urandom))}, {1'b1, 24'($urandom)});
        for (int i = 0; i < 200; i++) begin
            if (i == 50) hold_req = 80;
            if (i == 120) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (board.pending() != 0) @(posedge aclk);
            end
            send_pixel(rand_pixel());
        end
        drain();

        idle_pct = 0;
        set_key(300, 420, 0, 100, 0, 100, {1'b1, 24'h00FF00}, {1'b0, 24'($urandom)});
        repeat (200) send_pixel(rand_pixel());
        drain();
        idle_pct = 24;

        set_key(1023, 0, 127, 0, 127, 0, 25'h1FFFFFF, 25'h1000000);
        repeat (150) send_pixel(rand_pixel());
        drain();

        set_key(0, 1023, 0, 127, 0, 127, {1'b1, 24'($urandom)}, 25'h0);
        repeat (150) send_pixel(rand_pixel());
        drain();

        // Over-wide values are masked to each register's width.
        for (int r = 0; r < 8; r++) write_reg(hrk_pkg::reg_idx_t'(r), $urandom);
        repeat (150) send_pixel(rand_pixel());
        drain();

        repeat (4) begin
            random_key();
            repeat (225) send_pixel(rand_pixel());
            drain();
        end

        repeat (20) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
